>>> sv/sequence_gap_dup_reorder_monitor_core_assert.svh
// ---------------------------------------------------------------------------
// sequence gap / duplicate / reorder monitor assertion macros
// implication checks on the core clock, disabled during reset
// ---------------------------------------------------------------------------
`ifndef SEQUENCE_GAP_DUP_REORDER_MONITOR_CORE_ASSERT_SVH
`define SEQUENCE_GAP_DUP_REORDER_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define SGDRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGDRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SGDRM_ASSERT_IMP(lbl, ante, cons, msg)
`define SGDRM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/sgdrm_pkg.sv
// ---------------------------------------------------------------------------
// sgdrm_pkg
// types, codes and helpers of the sequence gap / duplicate / reorder monitor
// ---------------------------------------------------------------------------
package sgdrm_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_OBSERVE = 2'd0,
    FUNC_REPORT  = 2'd1,
    FUNC_RESET   = 2'd2
  } func_e;

  // result classification
  typedef enum logic [2:0] {
    KIND_IGNORED    = 3'd0,
    KIND_FIRST      = 3'd1,
    KIND_IN_ORDER   = 3'd2,
    KIND_DUP        = 3'd3,
    KIND_GAP        = 3'd4,
    KIND_REORDER    = 3'd5,
    KIND_REPORT     = 3'd6,
    KIND_RESET_DONE = 3'd7
  } kind_e;

  // per-stream event counters
  typedef struct packed {
    logic [31:0] dup;
    logic [31:0] reo;
    logic [31:0] gap;
    logic [31:0] max_gap;
    logic [31:0] max_reo;
  } cnt_t;

  // saturating increment
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  // clamp a 33-bit distance to 32 bits
  function automatic logic [31:0] sat_dist(input logic [32:0] d);
    return d[32] ? 32'hFFFF_FFFF : d[31:0];
  endfunction

endpackage

>>> sv/sequence_gap_dup_reorder_monitor_core.sv
// ---------------------------------------------------------------------------
// sequence_gap_dup_reorder_monitor_core
// per-stream sequence index checker with saturating event counters
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) carries one item of
// func_i, stream_i and index_i. func observe classifies index_i against the
// stream's expected index, report returns the counters and clears them,
// reset clears the whole stream. Every item yields exactly one result on the
// output channel (out_valid_o / out_ready_i).
// Path: an accepted item moves through the read stage and then into the
// result register, where the result is valid and waits to be taken.
// Throughput: one item per cycle while out_ready_i is high. State sits in
// two registered-read memories; an item reads its entry when accepted and
// writes it back on entering the result register; a write-back forward
// register covers an item that reads the entry written in the same cycle.
// Reset: all streams return to "nothing expected" with zero counters at
// once, through one valid bit per entry; no clearing pass is needed.
// Stall: when out_ready_i is low the result register holds, the item in
// the read stage waits, and in_ready_o is high only while that stage is
// free or moving on, so at most two items are held inside.
// ---------------------------------------------------------------------------
module sequence_gap_dup_reorder_monitor_core #(
  parameter int STREAMS    = 2,
  parameter int INDEX_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic        stream_i,
  input  logic [31:0] index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] distance_o,
  output logic [31:0] dup_total_o,
  output logic [31:0] reorder_total_o,
  output logic [31:0] gap_total_o,
  output logic [31:0] largest_gap_o,
  output logic [31:0] largest_reorder_o,
  output logic        any_events_o
);

  localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int EW = IW + 1;
  localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam logic [31:0] IDX_MASK = 32'((64'd1 << IW) - 64'd1);

  // state memories
  logic [EW-1:0]       exp_mem [STREAMS];
  sgdrm_pkg::cnt_t     cnt_mem [STREAMS];
  logic [STREAMS-1:0]  vld_q;

  // read stage
  logic                s1_valid_q;
  logic [1:0]          s1_func_q;
  logic                s1_oor_q;
  logic [31:0]         s1_idx_q;
  logic [SW-1:0]       s1_addr_q;
  logic [EW-1:0]       exp_rd_q;
  sgdrm_pkg::cnt_t     cnt_rd_q;
  logic                rvld_q;
  logic                fwd_q;
  logic [EW-1:0]       wb_e_q;
  sgdrm_pkg::cnt_t     wb_c_q;

  // result register
  logic                out_valid_q;
  sgdrm_pkg::kind_e    kind_q;
  logic [31:0]         dist_q;
  sgdrm_pkg::cnt_t     show_q;
  logic                any_q;

  logic                acc;
  logic                s1_adv;
  logic                wr_en;
  logic [SW-1:0]       in_addr;
  logic                in_oor;

  logic [EW-1:0]       cur_e;
  sgdrm_pkg::cnt_t     cur_c;
  logic [EW-1:0]       new_e;
  sgdrm_pkg::cnt_t     new_c;
  sgdrm_pkg::cnt_t     show_d;
  sgdrm_pkg::kind_e    kind_d;
  logic [31:0]         dist_d;
  logic [32:0]         idx33;
  logic [32:0]         e33;
  logic [32:0]         inc33;
  logic [31:0]         gap_d;
  logic [31:0]         reo_d;

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;
  assign wr_en      = s1_adv && !s1_oor_q;
  assign in_addr    = SW'(stream_i);
  assign in_oor     = 32'(stream_i) >= 32'(STREAMS);

  // memory write-back and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      exp_mem[s1_addr_q] <= new_e;
      cnt_mem[s1_addr_q] <= new_c;
    end
    if (acc) begin
      exp_rd_q <= exp_mem[in_addr];
      cnt_rd_q <= cnt_mem[in_addr];
    end
  end

  // read stage control, entry valid bits and forward flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vld_q      <= '0;
      rvld_q     <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
        rvld_q     <= in_oor ? 1'b0 : vld_q[in_addr];
        fwd_q      <= wr_en && !in_oor && (s1_addr_q == in_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // read stage payload and write-back copy
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_func_q <= func_i;
      s1_oor_q  <= in_oor;
      s1_idx_q  <= index_i & IDX_MASK;
      s1_addr_q <= in_addr;
    end
    if (wr_en) begin
      wb_e_q <= new_e;
      wb_c_q <= new_c;
    end
  end

  // classify and update
  always_comb begin
    cur_e  = fwd_q ? wb_e_q : (rvld_q ? exp_rd_q : '0);
    cur_c  = fwd_q ? wb_c_q : (rvld_q ? cnt_rd_q : '0);
    idx33  = {1'b0, s1_idx_q};
    e33    = 33'(cur_e);
    inc33  = idx33 + 33'd1;
    gap_d  = sgdrm_pkg::sat_dist(idx33 - e33);
    reo_d  = sgdrm_pkg::sat_dist(e33 - 33'd1 - idx33);
    new_e  = cur_e;
    new_c  = cur_c;
    kind_d = sgdrm_pkg::KIND_IGNORED;
    dist_d = '0;
    unique case (s1_func_q)
      sgdrm_pkg::FUNC_REPORT: begin
        kind_d = sgdrm_pkg::KIND_REPORT;
        new_c  = '0;
      end
      sgdrm_pkg::FUNC_RESET: begin
        kind_d = sgdrm_pkg::KIND_RESET_DONE;
        new_e  = '0;
        new_c  = '0;
      end
      sgdrm_pkg::FUNC_OBSERVE: begin
        if (s1_idx_q != '0) begin
          priority if (e33 == '0) begin
            kind_d = sgdrm_pkg::KIND_FIRST;
            new_e  = EW'(inc33);
          end else if (idx33 == e33) begin
            kind_d = sgdrm_pkg::KIND_IN_ORDER;
            new_e  = EW'(inc33);
          end else if (inc33 == e33) begin
            kind_d    = sgdrm_pkg::KIND_DUP;
            new_c.dup = sgdrm_pkg::sat_inc(cur_c.dup);
          end else if (idx33 > e33) begin
            kind_d    = sgdrm_pkg::KIND_GAP;
            dist_d    = gap_d;
            new_c.gap = sgdrm_pkg::sat_inc(cur_c.gap);
            if (gap_d > cur_c.max_gap) begin
              new_c.max_gap = gap_d;
            end
            new_e = EW'(inc33);
          end else begin
            kind_d    = sgdrm_pkg::KIND_REORDER;
            dist_d    = reo_d;
            new_c.reo = sgdrm_pkg::sat_inc(cur_c.reo);
            if (reo_d > cur_c.max_reo) begin
              new_c.max_reo = reo_d;
            end
          end
        end
      end
      default: ;
    endcase
    // a report shows the counters from before the clear
    show_d = (s1_func_q == sgdrm_pkg::FUNC_REPORT) ? cur_c : new_c;
    // stream beyond the configured count gives an all-zero ignored result
    if (s1_oor_q) begin
      kind_d = sgdrm_pkg::KIND_IGNORED;
      dist_d = '0;
      show_d = '0;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      kind_q <= kind_d;
      dist_q <= dist_d;
      show_q <= show_d;
      any_q  <= (show_d.dup != '0) || (show_d.reo != '0) || (show_d.gap != '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign distance_o        = dist_q;
  assign dup_total_o       = show_q.dup;
  assign reorder_total_o   = show_q.reo;
  assign gap_total_o       = show_q.gap;
  assign largest_gap_o     = show_q.max_gap;
  assign largest_reorder_o = show_q.max_reo;
  assign any_events_o      = any_q;

  // checks
`include "sequence_gap_dup_reorder_monitor_core_assert.svh"

  `SGDRM_ASSERT_IMP(a_fwd_needs_item, fwd_q, s1_valid_q, "forward flag without item in read stage")
  `SGDRM_ASSERT_IMP(a_dist_kind, out_valid_o && (distance_o != '0), (kind_q == sgdrm_pkg::KIND_GAP) || (kind_q == sgdrm_pkg::KIND_REORDER), "distance on non gap or reorder result")
  `SGDRM_ASSERT_IMP(a_reset_zero, out_valid_o && (kind_q == sgdrm_pkg::KIND_RESET_DONE), !any_events_o && (largest_gap_o == '0) && (largest_reorder_o == '0), "stream reset left counters")
  `SGDRM_ASSERT_NXT(a_stall_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(show_q), "stalled result changed")

endmodule
